[rtl/gba_pkg.sv]
package gba_pkg;

  localparam int RomW   = 18;
  localparam int RomMax = 4096;
  localparam int DataW  = 16;

  localparam logic [63:0] Ln2Q32     = 64'd2977044472;
  localparam logic [63:0] InvSqrt2Pi = 64'd1713444047;
  localparam logic [63:0] OneQ32     = 64'd4294967296;

  typedef logic signed [RomW-1:0] rom_t [RomMax+1];

  typedef struct packed {
    logic [15:0]              frac;
    logic signed [DataW-1:0]  dy;
    logic signed [DataW-1:0]  dx;
    logic                     last;
  } lookup_t;

  typedef struct packed {
    logic signed [RomW-1:0]   g;
    logic signed [DataW-1:0]  dy;
    logic signed [DataW-1:0]  dx;
    logic                     last;
  } term_t;

  // gelu derivative samples in q16, built by trapezoid integration of phi
  // codes are walked as 257 blocks of 256 to keep each loop short
  function automatic rom_t build_rom(input int entries);
    rom_t               rom;
    logic [63:0]        t;
    logic [63:0]        n;
    logic [63:0]        r;
    logic [63:0]        term;
    logic [63:0]        e;
    logic [63:0]        p;
    logic [63:0]        prev;
    logic [63:0]        acc;
    logic signed [63:0] sum;
    logic signed [63:0] c;
    logic signed [63:0] g;
    int                 k;
    int                 j;
    rom  = '{default: '0};
    acc  = '0;
    prev = '0;
    k    = 0;
    for (int jh = 0; jh <= 256; jh++) begin
      for (int jl = 0; jl < 256; jl++) begin
        j = jh * 256 + jl;
        if (j <= 65536) begin
          c = 64'(j) - 64'sd32768;
          t = 64'(c * c) << 7;
          n = t / Ln2Q32;
          if (n >= 64'd40) begin
            p = '0;
          end else begin
            r    = t - n * Ln2Q32;
            term = OneQ32;
            sum  = $signed(OneQ32);
            for (int i = 1; i <= 14; i++) begin
              term = (term * r) >> 32;
              case (i)
                1:  term = term / 1;
                2:  term = term / 2;
                3:  term = term / 3;
                4:  term = term / 4;
                5:  term = term / 5;
                6:  term = term / 6;
                7:  term = term / 7;
                8:  term = term / 8;
                9:  term = term / 9;
                10: term = term / 10;
                11: term = term / 11;
                12: term = term / 12;
                13: term = term / 13;
                14: term = term / 14;
                default: term = term;
              endcase
              if (i[0]) begin
                sum = sum - $signed(term);
              end else begin
                sum = sum + $signed(term);
              end
            end
            if (sum < 0) begin
              sum = '0;
            end
            e = 64'(sum) >> n;
            p = (e * InvSqrt2Pi) >> 32;
          end
          if (j > 0) begin
            acc = acc + prev + p;
          end
          prev = p;
          if (k <= entries && 64'(k) * 64'd65536 >= 64'(j) * 64'(entries) &&
              64'(k) * 64'd65536 < 64'(j + 1) * 64'(entries)) begin
            g      = $signed(acc >> 13) + ((c * $signed(p)) >>> 12);
            rom[k] = RomW'((g + 64'sd32768) >>> 16);
            k++;
          end
        end
      end
    end
    return rom;
  endfunction

endpackage

[rtl/gba_index.sv]
module gba_index #(
  parameter int TABLE_ENTRIES = 256,
  localparam int IdxW = $clog2(TABLE_ENTRIES)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [gba_pkg::DataW-1:0]     x,
  input  gba_pkg::lookup_t              up_lk,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [IdxW-1:0]               idx,
  output gba_pkg::lookup_t              dn_lk
);

  localparam int PosW = 16 + IdxW;

  logic                 v_r;
  logic [IdxW-1:0]      idx_r;
  gba_pkg::lookup_t     lk_r;
  logic                 en;
  logic [15:0]          u;
  logic [PosW-1:0]      pos;
  gba_pkg::lookup_t     lk_nxt;

  // offset binary position on the table grid
  assign u   = x ^ 16'h8000;
  assign pos = PosW'(u) * PosW'(TABLE_ENTRIES);
  assign en  = !v_r || dn_ready;

  always_comb begin
    lk_nxt      = up_lk;
    lk_nxt.frac = pos[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
    if (en) begin
      idx_r <= pos[PosW-1:16];
      lk_r  <= lk_nxt;
    end
  end

  assign up_ready = en;
  assign dn_valid = v_r;
  assign idx      = idx_r;
  assign dn_lk    = lk_r;

endmodule

[rtl/gba_interp.sv]
module gba_interp #(
  parameter int TABLE_ENTRIES = 256,
  localparam int IdxW = $clog2(TABLE_ENTRIES)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [IdxW-1:0]       idx,
  input  gba_pkg::lookup_t      up_lk,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output gba_pkg::term_t        dn_term
);

  localparam int RomW    = gba_pkg::RomW;
  localparam int RomIdxW = $clog2(gba_pkg::RomMax + 1);
  localparam gba_pkg::rom_t Rom = gba_pkg::build_rom(TABLE_ENTRIES);

  logic                       a_v_r;
  logic signed [RomW-1:0]     a_lo_r;
  logic signed [RomW-1:0]     a_hi_r;
  gba_pkg::lookup_t           a_lk_r;
  logic                       b_v_r;
  gba_pkg::term_t             b_term_r;
  gba_pkg::term_t             b_term_nxt;
  logic                       en_a;
  logic                       en_b;
  logic [RomIdxW-1:0]         idx_lo;
  logic [RomIdxW-1:0]         idx_hi;
  logic signed [RomW:0]       diff;
  logic signed [RomW+17:0]    prod;
  logic signed [RomW+17:0]    g_wide;

  assign en_b   = !b_v_r || dn_ready;
  assign en_a   = !a_v_r || en_b;
  assign idx_lo = RomIdxW'(idx);
  assign idx_hi = RomIdxW'(idx) + RomIdxW'(1);

  // interpolation between neighboring samples
  assign diff   = (RomW+1)'(a_hi_r) - (RomW+1)'(a_lo_r);
  assign prod   = diff * $signed({1'b0, a_lk_r.frac});
  assign g_wide = (RomW+18)'(a_lo_r) + (prod >>> 16);

  always_comb begin
    b_term_nxt.g    = g_wide[RomW-1:0];
    b_term_nxt.dy   = a_lk_r.dy;
    b_term_nxt.dx   = a_lk_r.dx;
    b_term_nxt.last = a_lk_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (en_a) begin
        a_v_r <= up_valid;
      end
      if (en_b) begin
        b_v_r <= a_v_r;
      end
    end
    if (en_a) begin
      a_lo_r <= Rom[idx_lo];
      a_hi_r <= Rom[idx_hi];
      a_lk_r <= up_lk;
    end
    if (en_b) begin
      b_term_r <= b_term_nxt;
    end
  end

  assign up_ready = en_a;
  assign dn_valid = b_v_r;
  assign dn_term  = b_term_r;

endmodule

[rtl/gba_accum.sv]
module gba_accum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  gba_pkg::term_t                up_term,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [gba_pkg::DataW-1:0]     grad_acc_out,
  output logic                          saturated,
  output logic                          last_out
);

  localparam int RomW  = gba_pkg::RomW;
  localparam int DataW = gba_pkg::DataW;
  localparam int ProdW = RomW + DataW;
  localparam int SumW  = ProdW + 2;
  localparam int YW    = SumW - 16;

  logic                       c_v_r;
  logic signed [ProdW-1:0]    c_prod_r;
  logic signed [DataW-1:0]    c_dx_r;
  logic                       c_last_r;
  logic                       d_v_r;
  logic [DataW-1:0]           d_y_r;
  logic                       d_sat_r;
  logic                       d_last_r;
  logic                       en_c;
  logic                       en_d;
  logic signed [SumW-1:0]     s;
  logic signed [YW-1:0]       y;
  logic [DataW-1:0]           y_nxt;
  logic                       sat_nxt;

  assign en_d = !d_v_r || dn_ready;
  assign en_c = !c_v_r || en_d;

  // q28 sum, rounded half up back to q12
  assign s = (SumW'(c_dx_r) <<< 16) + SumW'(c_prod_r) + SumW'(32768);
  assign y = s[SumW-1:16];

  always_comb begin
    if (y > YW'(32767)) begin
      y_nxt   = 16'h7fff;
      sat_nxt = 1'b1;
    end else if (y < -YW'(32768)) begin
      y_nxt   = 16'h8000;
      sat_nxt = 1'b1;
    end else begin
      y_nxt   = y[DataW-1:0];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      if (en_c) begin
        c_v_r <= up_valid;
      end
      if (en_d) begin
        d_v_r <= c_v_r;
      end
    end
    if (en_c) begin
      c_prod_r <= up_term.g * up_term.dy;
      c_dx_r   <= up_term.dx;
      c_last_r <= up_term.last;
    end
    if (en_d) begin
      d_y_r    <= y_nxt;
      d_sat_r  <= sat_nxt;
      d_last_r <= c_last_r;
    end
  end

  assign up_ready     = en_c;
  assign dn_valid     = d_v_r;
  assign grad_acc_out = d_y_r;
  assign saturated    = d_sat_r;
  assign last_out     = d_last_r;

endmodule

[rtl/gelu_backward_accumulate.sv]
// channel  ports                     contents
// in       in_tvalid/tready/tdata    tdata: x_value, grad_out, grad_acc_in; tlast: last_in
// out      out_tvalid/tready/tdata   tdata: grad_acc_out; tuser: saturated; tlast: last_out
//
// one word per cycle sustained while out_tready stays high, result registered in the sum and clip stage
// stages: table position, rom read, interpolation, multiply, sum and clip
// synchronous active low reset clears the valid bits only, no clearing pass
// a stall holds every full stage, empty stages still fill behind it
module gelu_backward_accumulate #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [47:0]   in_tdata,   // x_value, grad_out, grad_acc_in
  input  logic          in_tlast,   // last_in
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [15:0]   out_tdata,  // grad_acc_out
  output logic          out_tuser,  // saturated
  output logic          out_tlast   // last_out
);

  localparam int IdxW = $clog2(TABLE_ENTRIES);

  gba_pkg::lookup_t   in_lk;
  gba_pkg::lookup_t   ix_lk;
  logic               ix_valid;
  logic               ix_ready;
  logic [IdxW-1:0]    ix_idx;
  gba_pkg::term_t     ip_term;
  logic               ip_valid;
  logic               ip_ready;

  always_comb begin
    in_lk.frac = '0;
    in_lk.dy   = in_tdata[31:16];
    in_lk.dx   = in_tdata[47:32];
    in_lk.last = in_tlast;
  end

  gba_index #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_index (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .x        (in_tdata[15:0]),
    .up_lk    (in_lk),
    .dn_valid (ix_valid),
    .dn_ready (ix_ready),
    .idx      (ix_idx),
    .dn_lk    (ix_lk)
  );

  gba_interp #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (ix_valid),
    .up_ready (ix_ready),
    .idx      (ix_idx),
    .up_lk    (ix_lk),
    .dn_valid (ip_valid),
    .dn_ready (ip_ready),
    .dn_term  (ip_term)
  );

  gba_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (ip_valid),
    .up_ready     (ip_ready),
    .up_term      (ip_term),
    .dn_valid     (out_tvalid),
    .dn_ready     (out_tready),
    .grad_acc_out (out_tdata),
    .saturated    (out_tuser),
    .last_out     (out_tlast)
  );

`ifndef SYNTHESIS
  a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 16'h7fff || out_tdata == 16'h8000)
    else $error("clipped word not at a bound");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");
`endif

endmodule

[tb/gelu_backward_accumulate_checker.sv]
module gelu_backward_accumulate_checker #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // x_value, grad_out, grad_acc_in
  input  logic        in_tlast,   // last_in
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // grad_acc_out
  input  logic        out_tuser,  // saturated
  input  logic        out_tlast,  // last_out
  output int          fail_count,
  output int          outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned LnTwoQ32      = 64'd2977044472;
  localparam longint unsigned InvRootTwoPi  = 64'd1713444047;
  localparam longint unsigned UnityQ32      = 64'd4294967296;

  typedef struct packed {
    logic [15:0] grad;
    logic        sat;
    logic        last;
  } grad_word_t;

  longint     deriv_rom [TABLE_ENTRIES+1];
  grad_word_t expected_grads [$];

  // standard normal density at q4.12 code c, in q32
  function automatic longint unsigned normal_pdf_q32(longint c);
    longint unsigned t;
    longint unsigned n;
    longint unsigned r;
    longint unsigned term;
    longint unsigned e;
    longint          sum;
    t = longint'(c * c);
    t = t << 7;
    n = t / LnTwoQ32;
    if (n >= 64'd40) begin
      return 0;
    end
    r    = t - n * LnTwoQ32;
    term = UnityQ32;
    sum  = longint'(UnityQ32);
    for (int i = 1; i <= 14; i++) begin
      term = ((term * r) >> 32) / longint'(i);
      if (i % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e = longint'(sum);
    e = e >> n;
    return (e * InvRootTwoPi) >> 32;
  endfunction

  // integrate the density by trapezoids and sample phi(x) + x*pdf(x)
  task automatic fill_deriv_rom();
    longint unsigned acc;
    longint unsigned prev;
    longint unsigned p;
    longint          c;
    longint          g;
    int              k;
    acc  = 0;
    prev = 0;
    k    = 0;
    for (int j = 0; j <= 65536; j++) begin
      c = longint'(j) - 32768;
      p = normal_pdf_q32(c);
      if (j > 0) begin
        acc = acc + prev + p;
      end
      prev = p;
      while (k <= TABLE_ENTRIES && (65536 * k) / TABLE_ENTRIES == j) begin
        g = longint'(acc >> 13) + ((c * longint'(p)) >>> 12);
        deriv_rom[k] = (g + 32768) >>> 16;
        k++;
      end
    end
  endtask

  function automatic grad_word_t gelu_grad_accumulate(logic [47:0] data, logic last);
    longint     x;
    longint     dy;
    longint     dx;
    longint     pos;
    longint     idx;
    longint     frac;
    longint     lo;
    longint     hi;
    longint     g;
    longint     s;
    longint     y;
    grad_word_t w;
    x    = $signed(data[15:0]);
    dy   = $signed(data[31:16]);
    dx   = $signed(data[47:32]);
    pos  = (x + 32768) * TABLE_ENTRIES;
    idx  = pos >>> 16;
    frac = pos & 64'hFFFF;
    if (idx > TABLE_ENTRIES - 1) begin
      idx = TABLE_ENTRIES - 1;
    end
    lo = deriv_rom[idx];
    hi = deriv_rom[idx+1];
    g  = lo + (((hi - lo) * frac) >>> 16);
    s  = dx * 65536 + g * dy;
    y  = (s + 32768) >>> 16;
    w.sat = 1'b0;
    if (y > 32767) begin
      y     = 32767;
      w.sat = 1'b1;
    end else if (y < -32768) begin
      y     = -32768;
      w.sat = 1'b1;
    end
    w.grad = y[15:0];
    w.last = last;
    return w;
  endfunction

  initial begin
    fill_deriv_rom();
  end

  always @(posedge clk) begin
    grad_word_t want;
    int         errs;
    errs = 0;
    if (!rst_n) begin
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_grads.size() == 0) begin
          $error("unexpected output word: grad_acc_out %0d", $signed(out_tdata));
          errs++;
        end else begin
          want = expected_grads.pop_front();
          if (out_tdata !== want.grad) begin
            $error("grad_acc_out: expected %0d, actual %0d", $signed(want.grad),
                   $signed(out_tdata));
            errs++;
          end
          if (out_tuser !== want.sat) begin
            $error("saturated: expected %0b, actual %0b", want.sat, out_tuser);
            errs++;
          end
          if (out_tlast !== want.last) begin
            $error("last_out: expected %0b, actual %0b", want.last, out_tlast);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_grads.push_back(gelu_grad_accumulate(in_tdata, in_tlast));
      end
      fail_count  <= fail_count + errs;
      outstanding <= expected_grads.size();
    end
  end

endmodule

[tb/gelu_backward_accumulate_tb.sv]
module gelu_backward_accumulate_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableEntries = 256;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // x_value, grad_out, grad_acc_in
  logic        in_tlast;   // last_in
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // grad_acc_out
  logic        out_tuser;  // saturated
  logic        out_tlast;  // last_out

  int fail_count;
  int outstanding;
  int send_idle;
  int recv_idle;
  int results_seen;
  bit hold_done;

  gelu_backward_accumulate #(.TABLE_ENTRIES(TableEntries)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  gelu_backward_accumulate_checker #(.TABLE_ENTRIES(TableEntries)) check_inst (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      results_seen <= 0;
    end else if (out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
    end
  end

  // receiver, with one long hold-off once the sender runs flat out
  initial begin
    out_tready = 1'b0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= 1500) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (200) @(negedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(logic [15:0] x, logic [15:0] dy, logic [15:0] dx, logic last);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {dx, dy, x};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    logic [15:0] x;
    logic [15:0] dy;
    logic [15:0] dx;
    int          mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(2);
      x    = 16'($urandom);
      dy   = 16'($urandom);
      dx   = 16'($urandom);
      if (mode == 1) begin
        dy = 16'($urandom_range(8191)) - 16'd4096;
        dx = 16'($urandom_range(16383)) - 16'd8192;
      end else if (mode == 2) begin
        x  = $urandom_range(1) ? 16'h8000 + 16'($urandom_range(511))
                               : 16'h7FFF - 16'($urandom_range(511));
        dx = $urandom_range(1) ? 16'h8000 + 16'($urandom_range(4095))
                               : 16'h7FFF - 16'($urandom_range(4095));
      end
      send_word(x, dy, dx, $urandom_range(15) == 0);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    send_idle = 24;
    recv_idle = 85;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes of x, table top, clipping both ways, last flag
    send_word(16'h8000, 16'h1000, 16'h0000, 1'b0);
    send_word(16'h7FFF, 16'h1000, 16'h0000, 1'b0);
    send_word(16'h7FF0, 16'h7FFF, 16'h0000, 1'b0);
    send_word(16'h0000, 16'h1000, 16'h0000, 1'b1);
    send_word(16'hFFFF, 16'h1000, 16'h0000, 1'b0);
    send_word(16'h0001, 16'h8000, 16'h0000, 1'b0);
    send_word(16'h1000, 16'h7FFF, 16'h7FFF, 1'b0);
    send_word(16'h1000, 16'h8000, 16'h8000, 1'b0);
    send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    send_word(16'h7FFF, 16'h8000, 16'h8000, 1'b0);
    send_word(16'h8000, 16'h7FFF, 16'h8000, 1'b0);
    send_word(16'h8000, 16'h8000, 16'h7FFF, 1'b0);
    send_word(16'hF000, 16'h1000, 16'h7FFF, 1'b0);
    send_word(16'h2000, 16'h0001, 16'h7FFF, 1'b0);
    send_word(16'h2000, 16'hFFFF, 16'h8000, 1'b0);
    send_word(16'h0100, 16'h0000, 16'h1234, 1'b1);
    send_word(16'hC000, 16'h4000, 16'hC000, 1'b0);
    send_word(16'h0FFF, 16'h0FFF, 16'h0FFF, 1'b1);
    send_random(630);
    drain();

    send_idle = 85;
    recv_idle = 24;
    send_random(650);
    drain();

    send_idle = 0;
    recv_idle = 0;
    send_random(650);
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
